// File: design/mrlf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlf_pkg: shared types and constants of the Modbus RTU link framer
// Phase, operation, result kind and status codes, the result group that
// travels from the front end to the back end, and queue sizing.
// ----------------------------------------------------------------------------
package mrlf_pkg;

	localparam int RX_BUF_BYTES_DEF = 256;
	localparam int QUEUE_DEPTH      = 4;
	localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);
	localparam int CFG_DATA_W       = 32;
	localparam int CFG_INDEX_W      = 2;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CHAR_TIMEOUT  = 2'd0,
		REG_FRAME_TIMEOUT = 2'd1,
		REG_RESP_TIMEOUT  = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		OP_TX_BYTE  = 2'd0,
		OP_RX_BYTE  = 2'd1,
		OP_TICK     = 2'd2,
		OP_CLR_FLAG = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_TX_BYTE = 2'd0,
		KIND_RX_BYTE = 2'd1,
		KIND_STATUS  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NO_RESP = 3'd1,
		ST_CRC_ERR = 3'd2,
		ST_LATE    = 3'd3,
		ST_SHORT   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_TX   = 3'd1,
		PH_WAIT = 3'd2,
		PH_RX   = 3'd3,
		PH_GAP  = 3'd4
	} phase_t;

	// All result beats caused by one input item.
	typedef struct packed {
		kind_t       kind;
		logic [1:0]  last_idx;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		status_t     status;
		logic [7:0]  length;
		logic        flag;
	} group_t;

	typedef struct packed {
		logic   valid;
		group_t grp;
	} grp_wr_t;

	typedef struct packed {
		logic   empty;
		logic   full;
		group_t head;
	} grp_rd_t;

endpackage

// File: design/mrlf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlf_front: item decode, CRC and frame timing
// Takes one item per cycle while the result queue is not full, updates the
// link state and CRCs, and pushes the item's result beats into that queue.
// ----------------------------------------------------------------------------
module mrlf_front #(
	parameter int RX_BUF_BYTES = mrlf_pkg::RX_BUF_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mrlf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mrlf_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                push,
	input  mrlf_pkg::op_t                       op,
	input  logic [7:0]                          data,
	input  logic                                last,
	input  logic                                q_full,
	output mrlf_pkg::grp_wr_t                   wr
);
	import mrlf_pkg::*;

	localparam int CNT_W = $clog2(RX_BUF_BYTES + 1);

	function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	logic [19:0]      char_to_q, frame_to_q;
	logic [31:0]      resp_to_q;
	phase_t           phase_q, phase_d;
	logic [15:0]      tx_crc_q, tx_crc_d, rx_crc_q, rx_crc_d;
	logic [31:0]      elapsed_q, elapsed_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             first_q, first_d, bcast_q, bcast_d;
	logic             late_q, late_d, flag_q, flag_d;

	logic             acc;
	logic [15:0]      tx_crc_new, rx_crc_new;
	logic [31:0]      elapsed_inc;
	logic [CNT_W-1:0] count_inc;
	logic             bcast_now;

	assign acc         = push && !q_full;
	assign tx_crc_new  = crc_fold(tx_crc_q, data);
	assign rx_crc_new  = crc_fold(rx_crc_q, data);
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;
	assign count_inc   = count_q + CNT_W'(1);
	assign bcast_now   = first_q ? (data == 8'h00) : bcast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_to_q  <= 20'd1750;
			frame_to_q <= 20'd3500;
			resp_to_q  <= 32'd1000000;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_CHAR_TIMEOUT:  char_to_q  <= cfg_data[19:0];
				REG_FRAME_TIMEOUT: frame_to_q <= cfg_data[19:0];
				REG_RESP_TIMEOUT:  resp_to_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tx_crc_q  <= CRC_INIT;
			rx_crc_q  <= CRC_INIT;
			elapsed_q <= '0;
			count_q   <= '0;
			first_q   <= 1'b1;
			bcast_q   <= 1'b0;
			late_q    <= 1'b0;
			flag_q    <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			tx_crc_q  <= tx_crc_d;
			rx_crc_q  <= rx_crc_d;
			elapsed_q <= elapsed_d;
			count_q   <= count_d;
			first_q   <= first_d;
			bcast_q   <= bcast_d;
			late_q    <= late_d;
			flag_q    <= flag_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		tx_crc_d  = tx_crc_q;
		rx_crc_d  = rx_crc_q;
		elapsed_d = elapsed_q;
		count_d   = count_q;
		first_d   = first_q;
		bcast_d   = bcast_q;
		late_d    = late_q;
		flag_d    = flag_q;
		wr        = '0;
		if (acc) begin
			unique case (op)
				OP_TX_BYTE: begin
					wr.valid         = 1'b1;
					wr.grp.kind      = KIND_TX_BYTE;
					wr.grp.b0        = data;
					wr.grp.b1        = tx_crc_new[7:0];
					wr.grp.b2        = tx_crc_new[15:8];
					wr.grp.last_idx  = last ? 2'd2 : 2'd0;
					wr.grp.status    = ST_OK;
					bcast_d          = bcast_now;
					if (last) begin
						// The CRC goes out low byte first; the reply wait starts unless broadcast.
						tx_crc_d  = CRC_INIT;
						first_d   = 1'b1;
						rx_crc_d  = CRC_INIT;
						count_d   = '0;
						late_d    = 1'b0;
						elapsed_d = '0;
						phase_d   = bcast_now ? PH_IDLE : PH_WAIT;
					end else begin
						tx_crc_d = tx_crc_new;
						first_d  = 1'b0;
						phase_d  = PH_TX;
					end
				end
				OP_RX_BYTE: begin
					if (phase_q == PH_WAIT || phase_q == PH_RX) begin
						if (count_q < CNT_W'(RX_BUF_BYTES)) begin
							rx_crc_d        = rx_crc_new;
							count_d         = count_inc;
							elapsed_d       = '0;
							phase_d         = (count_inc >= CNT_W'(RX_BUF_BYTES)) ?
								PH_GAP : PH_RX;
							wr.valid        = 1'b1;
							wr.grp.kind     = KIND_RX_BYTE;
							wr.grp.b0       = data;
							wr.grp.status   = ST_OK;
						end else begin
							late_d  = 1'b1;
							phase_d = PH_GAP;
						end
					end else if (phase_q == PH_GAP) begin
						late_d = 1'b1;
					end
				end
				OP_TICK: begin
					elapsed_d = elapsed_inc;
					if (phase_q == PH_WAIT) begin
						if (elapsed_inc >= resp_to_q) begin
							flag_d        = 1'b1;
							phase_d       = PH_IDLE;
							wr.valid      = 1'b1;
							wr.grp.kind   = KIND_STATUS;
							wr.grp.status = ST_NO_RESP;
						end
					end else if (phase_q == PH_RX || phase_q == PH_GAP) begin
						if (phase_q == PH_GAP || elapsed_inc > {12'd0, char_to_q}) begin
							phase_d = PH_GAP;
							if (elapsed_inc >= {12'd0, frame_to_q}) begin
								phase_d     = PH_IDLE;
								wr.valid    = 1'b1;
								wr.grp.kind = KIND_STATUS;
								if (count_q >= CNT_W'(2)) begin
									wr.grp.length = 8'(count_q - CNT_W'(2));
								end
								priority if (late_q) begin
									wr.grp.status = ST_LATE;
								end else if (count_q < CNT_W'(2)) begin
									wr.grp.status = ST_SHORT;
								end else if (rx_crc_q != 16'h0000) begin
									wr.grp.status = ST_CRC_ERR;
								end else begin
									wr.grp.status = ST_OK;
								end
							end
						end
					end
				end
				OP_CLR_FLAG: begin
					flag_d = 1'b0;
				end
				default: ;
			endcase
		end
		wr.grp.flag = flag_d;
	end

	property p_wait_empty;
		@(posedge clk) disable iff (!arst_n) phase_q == PH_WAIT |-> count_q == '0;
	endproperty
	a_wait_empty: assert property (p_wait_empty) else $error("count nonzero while waiting");

	property p_crc_restart;
		@(posedge clk) disable iff (!arst_n)
			(acc && op == OP_TX_BYTE && last) |=> (tx_crc_q == CRC_INIT && first_q);
	endproperty
	a_crc_restart: assert property (p_crc_restart) else $error("tx CRC not restarted");

	property p_status_idle;
		@(posedge clk) disable iff (!arst_n)
			(wr.valid && wr.grp.kind == KIND_STATUS) |=> phase_q == PH_IDLE;
	endproperty
	a_status_idle: assert property (p_status_idle) else $error("status without idle");

endmodule

// File: design/mrlf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlf_queue: result group queue
// Short queue of result groups between the front end and the back end, so
// that each side stalls on its own.
// ----------------------------------------------------------------------------
module mrlf_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  mrlf_pkg::grp_wr_t wr,
	input  logic              deq,
	output mrlf_pkg::grp_rd_t rd
);
	import mrlf_pkg::*;

	group_t              slots_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wptr_q, rptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_push, do_pop;

	assign rd.full  = count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH);
	assign rd.empty = count_q == '0;
	assign rd.head  = slots_q[rptr_q];
	assign do_push  = wr.valid && !rd.full;
	assign do_pop   = deq && !rd.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wptr_q] <= wr.grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + QUEUE_AW'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + QUEUE_AW'(1);
			end
			count_q <= count_q + (QUEUE_AW + 1)'(do_push) - (QUEUE_AW + 1)'(do_pop);
		end
	end

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n) count_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH);
	endproperty
	a_count_bound: assert property (p_count_bound) else $error("queue overflow");

	property p_push_grows;
		@(posedge clk) disable iff (!arst_n)
			(do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1;
	endproperty
	a_push_grows: assert property (p_push_grows) else $error("queue count lost a push");

	property p_ptr_gap;
		@(posedge clk) disable iff (!arst_n)
			(count_q != '0 && count_q != (QUEUE_AW + 1)'(QUEUE_DEPTH)) |-> wptr_q != rptr_q;
	endproperty
	a_ptr_gap: assert property (p_ptr_gap) else $error("queue pointers out of step");

endmodule

// File: design/mrlf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlf_back: result beat sequencer
// Unpacks the group at the head of the queue into single result beats and
// releases the group after its last beat is taken.
// ----------------------------------------------------------------------------
module mrlf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  mrlf_pkg::grp_rd_t rd,
	input  logic              pop,
	output logic              deq,
	output logic              empty,
	output logic [1:0]        kind,
	output logic [7:0]        data_res,
	output logic [2:0]        status,
	output logic [7:0]        length,
	output logic              timeout_flag,
	output logic              end_of_run
);
	import mrlf_pkg::*;

	logic [1:0] idx_q;
	logic       beat;
	logic       last_beat;

	assign empty        = rd.empty;
	assign beat         = pop && !rd.empty;
	assign last_beat    = idx_q == rd.head.last_idx;
	assign deq          = beat && last_beat;
	assign kind         = rd.head.kind;
	assign status       = rd.head.status;
	assign length       = rd.head.length;
	assign timeout_flag = rd.head.flag;
	assign end_of_run   = last_beat;

	always_comb begin
		unique case (idx_q)
			2'd0:    data_res = rd.head.b0;
			2'd1:    data_res = rd.head.b1;
			default: data_res = rd.head.b2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (beat) begin
			idx_q <= last_beat ? 2'd0 : idx_q + 2'd1;
		end
	end

	property p_idx_in_group;
		@(posedge clk) disable iff (!arst_n) !rd.empty |-> idx_q <= rd.head.last_idx;
	endproperty
	a_idx_in_group: assert property (p_idx_in_group) else $error("beat index past group");

	property p_partial_held;
		@(posedge clk) disable iff (!arst_n) idx_q != 2'd0 |-> !rd.empty;
	endproperty
	a_partial_held: assert property (p_partial_held) else $error("partial group lost");

	property p_mid_beat_stays;
		@(posedge clk) disable iff (!arst_n)
			(beat && !last_beat) |=> (idx_q == $past(idx_q) + 2'd1);
	endproperty
	a_mid_beat_stays: assert property (p_mid_beat_stays) else $error("beat index skipped");

endmodule

// File: design/modbus_rtu_link_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_link_framer: Modbus RTU master link framer with CRC-16
// Transmit framing with CRC append, reply timing and received frame checks.
// ----------------------------------------------------------------------------
// One input item is accepted per clock whenever full is low; its state update
// and CRC-16 fold finish in that cycle, and its result group is registered into
// the queue, behind any groups still waiting. A transmit byte marked last
// gives three result beats (the byte, then the CRC low and high bytes), any
// other item at most one, and results leave at one beat per pop. A four-group
// queue sits between the item decoder and the beat sequencer, so full rises
// only when four item groups are waiting; sustained input rate is then set by
// how fast beats are popped. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module modbus_rtu_link_framer #(
	parameter int RX_BUF_BYTES = mrlf_pkg::RX_BUF_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mrlf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mrlf_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             push,
	output logic                             full,
	input  mrlf_pkg::op_t                    op,
	input  logic [7:0]                       data,
	input  logic                             last,
	output logic                             empty,
	input  logic                             pop,
	output logic [1:0]                       kind,
	output logic [7:0]                       data_res,
	output logic [2:0]                       status,
	output logic [7:0]                       length,
	output logic                             timeout_flag,
	output logic                             end_of_run
);
	import mrlf_pkg::*;

	grp_wr_t wr;
	grp_rd_t rd;
	logic    deq;

	assign full = rd.full;

	mrlf_front #(
		.RX_BUF_BYTES(RX_BUF_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.push     (push),
		.op       (op),
		.data     (data),
		.last     (last),
		.q_full   (rd.full),
		.wr       (wr)
	);

	mrlf_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (wr),
		.deq   (deq),
		.rd    (rd)
	);

	mrlf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd          (rd),
		.pop         (pop),
		.deq         (deq),
		.empty       (empty),
		.kind        (kind),
		.data_res    (data_res),
		.status      (status),
		.length      (length),
		.timeout_flag(timeout_flag),
		.end_of_run  (end_of_run)
	);

endmodule

// File: bench/tb_modbus_rtu_link_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_rtu_link_framer: self-checking bench for the Modbus RTU framer
// A directed table walks reset values, extreme and zero timeouts, broadcast,
// no-response, late, excess and short frames. Random request/response
// exchanges with good, corrupted, short, late and abandoned replies follow.
// Every result beat is checked field by field against a model of the framer
// kept inside the bench, with random idle bursts on both queue sides.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_link_framer;
	import mrlf_pkg::*;

	localparam int RX_BUF      = RX_BUF_BYTES_DEF;
	localparam int RAND_ITEMS  = 160;
	localparam int SETTLE      = 4;
	localparam int STALL_LIMIT = 2000;
	localparam int PRINT_CAP   = 200;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		status_t    st;
		logic [7:0] len;
		logic       flag;
		logic       eor;
	} beat_t;

	typedef struct {
		bit          is_reg;
		reg_index_t  idx;
		logic [31:0] cfg_value;
		op_t         op;
		logic [7:0]  data;
		logic        last;
		int          rep;
		bit          typed;
		beat_t       beat;
	} plan_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   push = 1'b0;
	logic                   full;
	op_t                    op = OP_TX_BYTE;
	logic [7:0]             data = 8'h00;
	logic                   last = 1'b0;
	logic                   empty;
	logic                   pop = 1'b0;
	logic [1:0]             kind;
	logic [7:0]             data_res;
	logic [2:0]             status;
	logic [7:0]             length;
	logic                   timeout_flag;
	logic                   end_of_run;

	// Bench copy of the framer state and its timing registers.
	phase_t      ph;
	logic [15:0] tx_crc;
	logic [15:0] rx_crc;
	logic [31:0] elapsed;
	int          rx_count;
	bit          addr_pending;
	bit          is_bcast;
	bit          late_seen;
	bit          no_reply;
	logic [31:0] char_gap;
	logic [31:0] frame_gap;
	logic [31:0] resp_limit;

	beat_t     step_beats[$];
	beat_t     pending_beats[$];
	plan_row_t plan[$];
	beat_t     want;

	int mismatches = 0;
	int items_sent = 0;
	int counted_items = 0;
	int beats_checked = 0;
	int status_seen = 0;
	int good_frames = 0;
	int idle_cycles = 0;
	int pop_hold = 0;
	bit idle_on = 1'b1;
	bit quiet = 1'b0;

	modbus_rtu_link_framer #(
		.RX_BUF_BYTES(RX_BUF)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.op(op),
		.data(data),
		.last(last),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.data_res(data_res),
		.status(status),
		.length(length),
		.timeout_flag(timeout_flag),
		.end_of_run(end_of_run)
	);

	always #5 clk = ~clk;

	function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	function automatic void add_beat(kind_t k, logic [7:0] v, status_t s, logic [7:0] n);
		beat_t b;
		b.kind = k;
		b.value = v;
		b.st = s;
		b.len = n;
		b.flag = no_reply;
		b.eor = 1'b0;
		step_beats.push_back(b);
	endfunction

	function automatic beat_t fixed_beat(kind_t k, logic [7:0] v, status_t s, logic [7:0] n,
			logic f);
		beat_t b;
		b.kind = k;
		b.value = v;
		b.st = s;
		b.len = n;
		b.flag = f;
		b.eor = 1'b1;
		return b;
	endfunction

	function automatic plan_row_t blank_row();
		plan_row_t r;
		r.is_reg = 1'b0;
		r.idx = REG_CHAR_TIMEOUT;
		r.cfg_value = '0;
		r.op = OP_TX_BYTE;
		r.data = 8'h00;
		r.last = 1'b0;
		r.rep = 0;
		r.typed = 1'b0;
		r.beat = '0;
		return r;
	endfunction

	function automatic void plan_reg(reg_index_t idx, logic [31:0] v);
		plan_row_t r;
		r = blank_row();
		r.is_reg = 1'b1;
		r.idx = idx;
		r.cfg_value = v;
		plan.push_back(r);
	endfunction

	function automatic void plan_item(op_t o, logic [7:0] d, logic l, int rep);
		plan_row_t r;
		r = blank_row();
		r.op = o;
		r.data = d;
		r.last = l;
		r.rep = rep;
		plan.push_back(r);
	endfunction

	function automatic void plan_check(op_t o, logic [7:0] d, logic l, beat_t b);
		plan_row_t r;
		r = blank_row();
		r.op = o;
		r.data = d;
		r.last = l;
		r.rep = 1;
		r.typed = 1'b1;
		r.beat = b;
		plan.push_back(r);
	endfunction

	// Works out the result beats of one accepted item into step_beats.
	task automatic framer_step(op_t o, logic [7:0] d, logic l);
		status_t st;
		logic [7:0] n;
		beat_t b;
		step_beats.delete();
		case (o)
			OP_TX_BYTE: begin
				if (addr_pending) begin
					is_bcast = (d == 8'h00);
					addr_pending = 1'b0;
				end
				tx_crc = crc16_byte(tx_crc, d);
				ph = PH_TX;
				add_beat(KIND_TX_BYTE, d, ST_OK, 8'd0);
				if (l) begin
					add_beat(KIND_TX_BYTE, tx_crc[7:0], ST_OK, 8'd0);
					add_beat(KIND_TX_BYTE, tx_crc[15:8], ST_OK, 8'd0);
					tx_crc = CRC_INIT;
					addr_pending = 1'b1;
					rx_crc = CRC_INIT;
					rx_count = 0;
					late_seen = 1'b0;
					elapsed = '0;
					ph = is_bcast ? PH_IDLE : PH_WAIT;
				end
			end
			OP_RX_BYTE: begin
				if (ph == PH_WAIT || ph == PH_RX) begin
					if (rx_count < RX_BUF) begin
						rx_crc = crc16_byte(rx_crc, d);
						rx_count++;
						elapsed = '0;
						ph = (rx_count >= RX_BUF) ? PH_GAP : PH_RX;
						add_beat(KIND_RX_BYTE, d, ST_OK, 8'd0);
					end else begin
						late_seen = 1'b1;
						ph = PH_GAP;
					end
				end else if (ph == PH_GAP) begin
					late_seen = 1'b1;
				end
			end
			OP_TICK: begin
				if (elapsed != 32'hFFFF_FFFF)
					elapsed++;
				if (ph == PH_WAIT) begin
					if (elapsed >= resp_limit) begin
						no_reply = 1'b1;
						ph = PH_IDLE;
						add_beat(KIND_STATUS, 8'd0, ST_NO_RESP, 8'd0);
					end
				end else if (ph == PH_RX || ph == PH_GAP) begin
					if (ph == PH_RX && elapsed > char_gap)
						ph = PH_GAP;
					if (ph == PH_GAP && elapsed >= frame_gap) begin
						n = (rx_count >= 2) ? 8'(rx_count - 2) : 8'd0;
						if (late_seen)
							st = ST_LATE;
						else if (rx_count < 2)
							st = ST_SHORT;
						else if (rx_crc != 16'h0000)
							st = ST_CRC_ERR;
						else
							st = ST_OK;
						ph = PH_IDLE;
						add_beat(KIND_STATUS, 8'd0, st, n);
					end
				end
			end
			default: no_reply = 1'b0;
		endcase
		if (step_beats.size() > 0) begin
			b = step_beats.pop_back();
			b.eor = 1'b1;
			step_beats.push_back(b);
		end
	endtask

	// Called right after a rising edge; returns at the edge that accepted the item.
	task automatic send_item(op_t o, logic [7:0] d, logic l, bit typed, beat_t fixed);
		int gap;
		gap = 0;
		if (idle_on && !quiet && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		op <= o;
		data <= d;
		last <= l;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
		if (!(o == OP_RX_BYTE && (ph == PH_IDLE || ph == PH_TX)))
			counted_items++;
		framer_step(o, d, l);
		if (typed)
			pending_beats.push_back(fixed);
		else
			foreach (step_beats[j])
				pending_beats.push_back(step_beats[j]);
	endtask

	task automatic send(op_t o, logic [7:0] d, logic l);
		send_item(o, d, l, 1'b0, '0);
	endtask

	task automatic drain_results();
		push <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Leaves cfg_we high; the caller lowers it after the last write of a group.
	task automatic write_reg(reg_index_t idx, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			REG_CHAR_TIMEOUT:  char_gap = {12'd0, v[19:0]};
			REG_FRAME_TIMEOUT: frame_gap = {12'd0, v[19:0]};
			REG_RESP_TIMEOUT:  resp_limit = v;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic check_field(string what, logic [31:0] exp_val, logic [31:0] got);
		if (exp_val !== got) begin
			mismatches++;
			if (mismatches <= PRINT_CAP)
				$display("%0t: %s mismatch, expected %0h, actual %0h",
					$time, what, exp_val, got);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_hold > 0) begin
			pop <= 1'b0;
			pop_hold--;
		end else if (idle_on && !quiet && $urandom_range(0, 4) == 0) begin
			pop <= 1'b0;
			pop_hold = $urandom_range(0, 5);
		end else begin
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= PRINT_CAP)
					$display("%0t: result beat with nothing expected, actual kind %0d data %0h",
						$time, kind, data_res);
			end else begin
				want = pending_beats.pop_front();
				beats_checked++;
				if (want.kind == KIND_STATUS) begin
					status_seen++;
					if (want.st == ST_OK)
						good_frames++;
				end
				check_field("kind", 32'(want.kind), 32'(kind));
				check_field("data_res", 32'(want.value), 32'(data_res));
				check_field("status", 32'(want.st), 32'(status));
				check_field("length", 32'(want.len), 32'(length));
				check_field("timeout_flag", 32'(want.flag), 32'(timeout_flag));
				check_field("end_of_run", 32'(want.eor), 32'(end_of_run));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int k;
		int n_req;
		int n_body;
		int mode;
		int base;
		int next_retime;
		int gap_cap;
		logic [7:0] d;
		logic [15:0] c;
		logic [7:0] body[$];
		bit cfg_open;

		ph = PH_IDLE;
		tx_crc = CRC_INIT;
		rx_crc = CRC_INIT;
		elapsed = '0;
		rx_count = 0;
		addr_pending = 1'b1;
		is_bcast = 1'b0;
		late_seen = 1'b0;
		no_reply = 1'b0;
		char_gap = 32'd1750;
		frame_gap = 32'd3500;
		resp_limit = 32'd1000000;
		cfg_open = 1'b0;

		// Reset timing values: the frame is judged exactly at the 3500th tick.
		plan_item(OP_TX_BYTE, 8'h01, 1'b1, 1);
		plan_check(OP_RX_BYTE, 8'h01, 1'b0, fixed_beat(KIND_RX_BYTE, 8'h01, ST_OK, 8'd0, 1'b0));
		plan_item(OP_TICK, 8'h00, 1'b0, 1750);
		plan_item(OP_TICK, 8'h00, 1'b0, 1749);
		plan_check(OP_TICK, 8'h00, 1'b0, fixed_beat(KIND_STATUS, 8'h00, ST_SHORT, 8'd0, 1'b0));
		// Short timeouts; the unused index must not disturb anything.
		plan_reg(REG_CHAR_TIMEOUT, 32'd2);
		plan_reg(REG_FRAME_TIMEOUT, 32'd4);
		plan_reg(REG_RESP_TIMEOUT, 32'd3);
		plan_reg(REG_UNUSED, 32'hFFFF_FFFF);
		plan_item(OP_CLR_FLAG, 8'hFF, 1'b1, 1);
		plan_item(OP_TICK, 8'hFF, 1'b1, 1);
		plan_item(OP_RX_BYTE, 8'h5A, 1'b0, 1);
		plan_check(OP_TX_BYTE, 8'h01, 1'b0, fixed_beat(KIND_TX_BYTE, 8'h01, ST_OK, 8'd0, 1'b0));
		plan_item(OP_TX_BYTE, 8'hFF, 1'b1, 1);
		plan_item(OP_TICK, 8'h00, 1'b0, 2);
		plan_check(OP_TICK, 8'h00, 1'b0, fixed_beat(KIND_STATUS, 8'h00, ST_NO_RESP, 8'd0, 1'b1));
		plan_item(OP_CLR_FLAG, 8'h00, 1'b0, 1);
		plan_item(OP_TX_BYTE, 8'h00, 1'b1, 1);
		plan_item(OP_TX_BYTE, 8'h80, 1'b1, 1);
		plan_check(OP_RX_BYTE, 8'hFF, 1'b1, fixed_beat(KIND_RX_BYTE, 8'hFF, ST_OK, 8'd0, 1'b0));
		plan_item(OP_TICK, 8'h00, 1'b0, 3);
		plan_item(OP_RX_BYTE, 8'hAA, 1'b0, 1);
		plan_check(OP_TICK, 8'h00, 1'b0, fixed_beat(KIND_STATUS, 8'h00, ST_LATE, 8'd0, 1'b0));
		// A full receive buffer ends the frame; one more byte counts as excess.
		plan_item(OP_TX_BYTE, 8'h10, 1'b1, 1);
		plan_item(OP_RX_BYTE, 8'hC3, 1'b0, RX_BUF + 1);
		plan_item(OP_TICK, 8'h00, 1'b0, 3);
		plan_check(OP_TICK, 8'h00, 1'b0, fixed_beat(KIND_STATUS, 8'h00, ST_LATE, 8'd254, 1'b0));
		// Zero timeouts expire or judge on the first tick.
		plan_reg(REG_CHAR_TIMEOUT, 32'd0);
		plan_reg(REG_FRAME_TIMEOUT, 32'd0);
		plan_reg(REG_RESP_TIMEOUT, 32'd0);
		plan_item(OP_TX_BYTE, 8'h05, 1'b1, 1);
		plan_check(OP_TICK, 8'h00, 1'b0, fixed_beat(KIND_STATUS, 8'h00, ST_NO_RESP, 8'd0, 1'b1));
		plan_item(OP_TX_BYTE, 8'h05, 1'b1, 1);
		plan_check(OP_RX_BYTE, 8'h00, 1'b0, fixed_beat(KIND_RX_BYTE, 8'h00, ST_OK, 8'd0, 1'b1));
		plan_check(OP_TICK, 8'h00, 1'b0, fixed_beat(KIND_STATUS, 8'h00, ST_SHORT, 8'd0, 1'b1));
		// Largest timeouts; a transmit byte abandons the reception silently.
		plan_reg(REG_CHAR_TIMEOUT, 32'h000F_FFFF);
		plan_reg(REG_FRAME_TIMEOUT, 32'h000F_FFFF);
		plan_reg(REG_RESP_TIMEOUT, 32'hFFFF_FFFF);
		plan_item(OP_TX_BYTE, 8'h06, 1'b1, 1);
		plan_check(OP_RX_BYTE, 8'h01, 1'b0, fixed_beat(KIND_RX_BYTE, 8'h01, ST_OK, 8'd0, 1'b1));
		plan_check(OP_TX_BYTE, 8'h07, 1'b0, fixed_beat(KIND_TX_BYTE, 8'h07, ST_OK, 8'd0, 1'b1));
		plan_item(OP_CLR_FLAG, 8'h00, 1'b0, 1);
		plan_item(OP_TICK, 8'h00, 1'b0, 1);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			quiet = ($urandom_range(0, 3) == 0);
			if (plan[i].is_reg) begin
				if (!cfg_open)
					drain_results();
				write_reg(plan[i].idx, plan[i].cfg_value);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open) begin
					cfg_we <= 1'b0;
					cfg_open = 1'b0;
				end
				repeat (plan[i].rep)
					send_item(plan[i].op, plan[i].data, plan[i].last, plan[i].typed,
						plan[i].beat);
			end
		end

		base = counted_items;
		next_retime = 0;
		while (counted_items - base < RAND_ITEMS) begin
			if (counted_items - base >= next_retime) begin
				drain_results();
				write_reg(REG_CHAR_TIMEOUT, $urandom_range(0, 6));
				write_reg(REG_FRAME_TIMEOUT, $urandom_range(0, 10));
				write_reg(REG_RESP_TIMEOUT, $urandom_range(0, 12));
				if ($urandom_range(0, 1) == 1)
					write_reg(REG_UNUSED, $urandom);
				cfg_we <= 1'b0;
				next_retime += 40;
			end
			idle_on = (counted_items - base) < (RAND_ITEMS * 3) / 4;
			quiet = ($urandom_range(0, 3) == 0);
			mode = $urandom_range(0, 9);
			gap_cap = (char_gap > 6) ? 6 : int'(char_gap);

			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 3))
					send(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
			if (no_reply && $urandom_range(0, 2) == 0)
				send(OP_CLR_FLAG, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

			n_req = $urandom_range(1, 6);
			for (k = 0; k < n_req; k++) begin
				d = (k == 0 && $urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
				send(OP_TX_BYTE, d, k == n_req - 1);
			end

			if (ph == PH_WAIT) begin
				body.delete();
				if (mode == 6) begin
					body.push_back(8'($urandom_range(0, 255)));
				end else if (mode != 8) begin
					n_body = $urandom_range(0, 6);
					for (k = 0; k < n_body; k++)
						body.push_back(8'($urandom_range(0, 255)));
					c = CRC_INIT;
					foreach (body[j])
						c = crc16_byte(c, body[j]);
					body.push_back(c[7:0]);
					body.push_back(c[15:8]);
					if (mode == 5) begin
						k = $urandom_range(0, body.size() - 1);
						body[k] = body[k] ^ 8'($urandom_range(1, 255));
					end
				end
				for (k = 0; k < body.size(); k++) begin
					if (k > 0)
						repeat ($urandom_range(0, gap_cap))
							send(OP_TICK, 8'($urandom_range(0, 255)),
								1'($urandom_range(0, 1)));
					send(OP_RX_BYTE, body[k], 1'($urandom_range(0, 1)));
				end
				// Past the character gap but usually short of the frame gap.
				if (mode == 7) begin
					repeat (char_gap + 1)
						send(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
					send(OP_RX_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				end
				if (mode != 9)
					while (ph == PH_WAIT || ph == PH_RX || ph == PH_GAP)
						send(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
		end

		idle_on = 1'b0;
		push <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d input items (%0d counted in the random part), checked %0d beats.",
			items_sent, counted_items - base, beats_checked);
		$display("Saw %0d frame status reports, %0d of them good frames.",
			status_seen, good_frames);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches in total", mismatches);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// File: filelist.f
design/mrlf_pkg.sv
design/mrlf_front.sv
design/mrlf_queue.sv
design/mrlf_back.sv
design/modbus_rtu_link_framer.sv
bench/tb_modbus_rtu_link_framer.sv
